### sv/smg_pkg.sv
//------------------------------------------------------------------------------
// smg_pkg
// shared constants, types and functions for the square marker geometry block
//------------------------------------------------------------------------------
`default_nettype none
package smg_pkg;
  localparam int CW  = 16;               // coordinate width
  localparam int NST = 16;               // cordic stages
  localparam int DW  = CW + 1;           // signed difference width
  localparam int SQW = 2 * CW + 6;       // 16*(dx^2+dy^2) width
  localparam int RW  = SQW / 2;          // root width
  localparam int NRT = RW;               // root iterations
  localparam int ZW  = 26;               // angle accumulator width
  localparam int CXW = CW + 3;           // cordic x/y width
  localparam int LAT = (NRT > NST) ? NRT : NST;
  localparam int YAW_LIMIT = 11520;
  localparam int YAW_RIGHT = 5760;
  localparam int QUARTER_TURN = 1474560;

  typedef logic [CW-1:0] coord_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 26'sd737280;   1: t = 26'sd435242;   2: t = 26'sd229970;
      3: t = 26'sd116736;   4: t = 26'sd58595;    5: t = 26'sd29326;
      6: t = 26'sd14667;    7: t = 26'sd7334;     8: t = 26'sd3667;
      9: t = 26'sd1833;     10: t = 26'sd917;     11: t = 26'sd458;
      12: t = 26'sd229;     13: t = 26'sd115;     14: t = 26'sd57;
      15: t = 26'sd29;      16: t = 26'sd14;      17: t = 26'sd7;
      18: t = 26'sd4;       19: t = 26'sd2;       20: t = 26'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

### sv/square_marker_geometry.sv
//------------------------------------------------------------------------------
// square_marker_geometry
// centre, mean side length and yaw of a four-corner marker, fully pipelined
//------------------------------------------------------------------------------
// channel   | ports                                   | handshake
// command   | start, busy, corner0_x .. corner3_y     | start && !busy
// result    | done, centre_x, centre_y, side_mean,    | done, one cycle
//           | yaw_angle                               |
//
// one transaction per cycle; busy is tied low
// corners are registered at the accepting edge; done is delayed to match one squaring
// stage, LAT cell stages of the square root and cordic chains running side by side,
// and one output register
// rst clears the valid chain only; payload registers are not reset
// the receiver cannot stall, results are presented for exactly one cycle
//------------------------------------------------------------------------------
`default_nettype none
module square_marker_geometry import smg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] corner0_x,
  input  wire logic [15:0] corner0_y,
  input  wire logic [15:0] corner1_x,
  input  wire logic [15:0] corner1_y,
  input  wire logic [15:0] corner2_x,
  input  wire logic [15:0] corner2_y,
  input  wire logic [15:0] corner3_x,
  input  wire logic [15:0] corner3_y,
  output logic             done,
  output logic [15:0]      centre_x,
  output logic [15:0]      centre_y,
  output logic [16:0]      side_mean,
  output logic signed [14:0] yaw_angle
);
  localparam int D = LAT;  // depth of the side-band delay line

  assign busy = 1'b0;

  // stage 0: capture corners
  coord_t cx[4], cy[4];
  always_ff @(posedge clk) begin
    cx[0] <= corner0_x; cy[0] <= corner0_y;
    cx[1] <= corner1_x; cy[1] <= corner1_y;
    cx[2] <= corner2_x; cy[2] <= corner2_y;
    cx[3] <= corner3_x; cy[3] <= corner3_y;
  end

  // stage 1: differences, centres, squared side lengths, cordic prerotation, special-case flags
  logic [CW+1:0]  sumx, sumy;
  logic [SQW-1:0] sq[4];
  logic [CW-1:0]  adx[4], ady[4];
  logic signed [DW-1:0] ydx, ydy;
  logic signed [CXW-1:0] px, py;
  logic signed [ZW-1:0]  pz;
  logic spec;             // yaw fixed by an axis-aligned or zero direction
  logic signed [14:0] spec_val;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      adx[k] = (cx[k] > cx[(k+1)%4]) ? cx[k] - cx[(k+1)%4] : cx[(k+1)%4] - cx[k];
      ady[k] = (cy[k] > cy[(k+1)%4]) ? cy[k] - cy[(k+1)%4] : cy[(k+1)%4] - cy[k];
    end
    ydx = DW'(signed'({1'b0, cx[1]})) - DW'(signed'({1'b0, cx[0]}));
    ydy = DW'(signed'({1'b0, cy[1]})) - DW'(signed'({1'b0, cy[0]}));
    px = CXW'(ydx); py = CXW'(ydy); pz = '0;
    if (ydx < 0) begin
      if (ydy > 0) begin
        px = CXW'(ydy); py = -CXW'(ydx); pz = ZW'(QUARTER_TURN);
      end else begin
        px = -CXW'(ydy); py = CXW'(ydx); pz = -ZW'(QUARTER_TURN);
      end
    end
    spec = 1'b0; spec_val = '0;
    if (ydy == 0) begin
      spec = 1'b1; spec_val = (ydx < 0) ? 15'(YAW_LIMIT) : 15'sd0;
    end else if (ydx == 0) begin
      spec = 1'b1; spec_val = (ydy > 0) ? 15'(YAW_RIGHT) : -15'(YAW_RIGHT);
    end
  end

  // squares registered before the sum
  logic [2*CW-1:0] mx[4], my[4];
  logic [CW+1:0]   s1x, s1y;
  logic signed [CXW-1:0] qx, qy;
  logic signed [ZW-1:0]  qz;
  logic s1spec;
  logic signed [14:0] s1val;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      mx[k] <= adx[k] * adx[k];
      my[k] <= ady[k] * ady[k];
    end
    s1x <= (CW+2)'(cx[0]) + cx[1] + cx[2] + cx[3];
    s1y <= (CW+2)'(cy[0]) + cy[1] + cy[2] + cy[3];
    qx <= px; qy <= py; qz <= pz;
    s1spec <= spec; s1val <= spec_val;
  end
  always_comb begin
    sumx = s1x; sumy = s1y;
    for (int k = 0; k < 4; k++) sq[k] = ({6'b0, mx[k]} + {6'b0, my[k]}) << 4;
  end

  // root cell chains, one per side, padded to LAT cells
  logic [SQW-1:0] rv[4][LAT+1];
  logic [RW-1:0]  rr[4][LAT+1];
  for (genvar k = 0; k < 4; k++) begin : g_side
    assign rv[k][0] = sq[k];
    assign rr[k][0] = '0;
    for (genvar j = 0; j < LAT; j++) begin : g_cell
      smg_root_cell u_cell (
        .clk(clk), .step(6'(j)), .bypass(j >= NRT),
        .v_in(rv[k][j]), .r_in(rr[k][j]),
        .v_out(rv[k][j+1]), .r_out(rr[k][j+1])
      );
    end
  end

  // cordic cell chain, padded to LAT cells
  logic signed [CXW-1:0] ax[LAT+1], ay[LAT+1];
  logic signed [ZW-1:0]  az[LAT+1];
  assign ax[0] = qx; assign ay[0] = qy; assign az[0] = qz;
  for (genvar j = 0; j < LAT; j++) begin : g_cordic
    smg_cordic_cell u_cell (
      .clk(clk), .step(5'(j)), .bypass(j >= NST || j >= 24),
      .x_in(ax[j]), .y_in(ay[j]), .z_in(az[j]),
      .x_out(ax[j+1]), .y_out(ay[j+1]), .z_out(az[j+1])
    );
  end

  // side-band delay line for centres and special cases
  logic [CW+1:0] dsx[D], dsy[D];
  logic          dsp[D];
  logic signed [14:0] dsv[D];
  logic [LAT+1:0] vld;
  always_ff @(posedge clk) begin
    dsx[0] <= sumx; dsy[0] <= sumy; dsp[0] <= s1spec; dsv[0] <= s1val;
    for (int j = 1; j < D; j++) begin
      dsx[j] <= dsx[j-1]; dsy[j] <= dsy[j-1]; dsp[j] <= dsp[j-1]; dsv[j] <= dsv[j-1];
    end
    if (rst) vld <= '0;
    else     vld <= {vld[LAT:0], start};
  end

  // both chains are LAT cells long, so their outputs line up
  logic [RW+1:0] rsum;
  logic signed [ZW-1:0] zf, zr;
  logic signed [ZW-1:0] zq;
  always_comb begin
    rsum = (RW+2)'(rr[0][LAT]) + rr[1][LAT] + rr[2][LAT] + rr[3][LAT];
    zf = az[LAT];
    zr = (zf + ZW'(128)) >>> 8;
    zq = zr;
    if (zr > ZW'(YAW_LIMIT))  zq = ZW'(YAW_LIMIT);
    if (zr < -ZW'(YAW_LIMIT)) zq = -ZW'(YAW_LIMIT);
  end

  // output register
  always_ff @(posedge clk) begin
    centre_x  <= dsx[D-1][CW+1:2];
    centre_y  <= dsy[D-1][CW+1:2];
    side_mean <= 17'(rsum >> 4);
    yaw_angle <= dsp[D-1] ? dsv[D-1] : zq[14:0];
    if (rst) done <= 1'b0;
    else     done <= vld[LAT+1];
  end
endmodule
`default_nettype wire

### sv/smg_root_cell.sv
//------------------------------------------------------------------------------
// smg_root_cell
// one step of the digit-by-digit square root, passing its remainder onward
//------------------------------------------------------------------------------
`default_nettype none
module smg_root_cell import smg_pkg::*; (
  input  wire logic           clk,
  input  wire logic [5:0]     step,      // fixed position of this cell
  input  wire logic           bypass,    // padding cell beyond the root length
  input  wire logic [SQW-1:0] v_in,
  input  wire logic [RW-1:0]  r_in,
  output logic      [SQW-1:0] v_out,
  output logic      [RW-1:0]  r_out
);
  // restoring root: try bit pair at position 2*(RW-1-step), trial is (4r+1) there
  logic [SQW+1:0] trial;
  logic [SQW+1:0] rem;
  logic [RW+1:0]  cand;
  always_comb begin
    cand  = {r_in, 2'b01};
    trial = {{(SQW-RW){1'b0}}, cand} << (2 * (RW - 1 - step));
    rem   = {2'b00, v_in};
  end
  always_ff @(posedge clk) begin
    if (bypass) begin
      v_out <= v_in;
      r_out <= r_in;
    end else if (rem >= trial) begin
      v_out <= SQW'(rem - trial);
      r_out <= {r_in[RW-2:0], 1'b1};
    end else begin
      v_out <= v_in;
      r_out <= {r_in[RW-2:0], 1'b0};
    end
  end
endmodule
`default_nettype wire

### sv/smg_cordic_cell.sv
//------------------------------------------------------------------------------
// smg_cordic_cell
// one vectoring cordic rotation stage with a registered output
//------------------------------------------------------------------------------
`default_nettype none
module smg_cordic_cell import smg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic [4:0]            step,
  input  wire logic                  bypass,  // stage beyond the configured count
  input  wire logic signed [CXW-1:0] x_in,
  input  wire logic signed [CXW-1:0] y_in,
  input  wire logic signed [ZW-1:0]  z_in,
  output logic signed [CXW-1:0]      x_out,
  output logic signed [CXW-1:0]      y_out,
  output logic signed [ZW-1:0]       z_out
);
  logic signed [CXW-1:0] xs, ys;
  always_comb begin
    xs = x_in >>> step;
    ys = y_in >>> step;
  end
  always_ff @(posedge clk) begin
    if (bypass) begin
      x_out <= x_in; y_out <= y_in; z_out <= z_in;
    end else if (y_in > 0) begin
      x_out <= x_in + ys; y_out <= y_in - xs; z_out <= z_in + atan_entry(int'(step));
    end else begin
      x_out <= x_in - ys; y_out <= y_in + xs; z_out <= z_in - atan_entry(int'(step));
    end
  end
endmodule
`default_nettype wire

### tb/sv/square_marker_geometry_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// square_marker_geometry_tb
// drives corner sets into the marker geometry pipeline and checks centre,
// mean side length and yaw against a behavioral predictor, under random idling
//------------------------------------------------------------------------------
module square_marker_geometry_tb;
  import smg_pkg::*;

  // one marker as the block sees it
  typedef struct packed {
    logic [15:0] x0, y0, x1, y1, x2, y2, x3, y3;
  } marker_t;

  // one set of geometry results
  typedef struct packed {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [16:0]        side;
    logic signed [14:0] yaw;
  } geom_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [15:0]        corner0_x, corner0_y, corner1_x, corner1_y;
  logic [15:0]        corner2_x, corner2_y, corner3_x, corner3_y;
  logic               done;
  logic [15:0]        centre_x, centre_y;
  logic [16:0]        side_mean;
  logic signed [14:0] yaw_angle;

  marker_t pending_markers[$];
  geom_t   expected_geometry[$];
  int      error_count;
  int      markers_sent;
  int      results_seen;
  int      idle_cycles;
  int      send_idle_pct;
  bit      stimulus_done;

  localparam int WATCHDOG_LIMIT = 2000;

  square_marker_geometry uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .corner0_x(corner0_x), .corner0_y(corner0_y),
    .corner1_x(corner1_x), .corner1_y(corner1_y),
    .corner2_x(corner2_x), .corner2_y(corner2_y),
    .corner3_x(corner3_x), .corner3_y(corner3_y),
    .done(done), .centre_x(centre_x), .centre_y(centre_y),
    .side_mean(side_mean), .yaw_angle(yaw_angle)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // bitwise integer square root, floor
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // quarter-pel side length with two fraction bits
  function automatic longint unsigned side_len(input longint ax, input longint ay,
                                               input longint bx, input longint by);
    longint dx;
    longint dy;
    dx = ax - bx;
    dy = ay - by;
    return isqrt(longint'(16) * (dx * dx + dy * dy));
  endfunction

  // arithmetic right shift rounding toward minus infinity
  function automatic longint fshift(input longint v, input int s);
    return v >>> s;
  endfunction

  // cordic vectoring yaw in 1/64 degree
  function automatic longint yaw_cordic(input longint dx, input longint dy);
    longint x, y, z, nx, ny, q;
    x = dx;
    y = dy;
    z = 0;
    if (dy == 0) return (dx < 0) ? YAW_LIMIT : 0;
    if (dx == 0) return (dy > 0) ? YAW_RIGHT : -YAW_RIGHT;
    if (x < 0) begin
      if (y > 0) begin
        x = dy;
        y = -dx;
        z = QUARTER_TURN;
      end else begin
        x = -dy;
        y = dx;
        z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < NST && i < 24; i++) begin
      if (y > 0) begin
        nx = x + fshift(y, i);
        ny = y - fshift(x, i);
        z = z + longint'(atan_entry(i));
      end else begin
        nx = x - fshift(y, i);
        ny = y + fshift(x, i);
        z = z - longint'(atan_entry(i));
      end
      x = nx;
      y = ny;
    end
    q = fshift(z + 128, 8);
    if (q > YAW_LIMIT) q = YAW_LIMIT;
    if (q < -YAW_LIMIT) q = -YAW_LIMIT;
    return q;
  endfunction

  // full geometry of one marker
  function automatic geom_t marker_geometry(input marker_t m);
    geom_t g;
    longint xs[4];
    longint ys[4];
    longint unsigned sum;
    xs = '{m.x0, m.x1, m.x2, m.x3};
    ys = '{m.y0, m.y1, m.y2, m.y3};
    sum = 0;
    for (int k = 0; k < 4; k++)
      sum += side_len(xs[k], ys[k], xs[(k + 1) % 4], ys[(k + 1) % 4]);
    g.cx   = 16'((xs[0] + xs[1] + xs[2] + xs[3]) >> 2);
    g.cy   = 16'((ys[0] + ys[1] + ys[2] + ys[3]) >> 2);
    g.side = 17'(sum >> 4);
    g.yaw  = 15'(yaw_cordic(xs[1] - xs[0], ys[1] - ys[0]));
    return g;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    error_count++;
  endtask

  // append one marker to the stimulus queue
  task automatic queue_marker(input marker_t m);
    pending_markers.insert(pending_markers.size(), m);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 31));
      3: return 16'($urandom_range(65504, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // a square-ish marker around a random centre with random rotation
  function automatic marker_t rand_square();
    marker_t m;
    int cx, cy, ux, uy;
    cx = $urandom_range(4000, 61535);
    cy = $urandom_range(4000, 61535);
    ux = int'($urandom_range(0, 3800)) - 1900;
    uy = int'($urandom_range(0, 3800)) - 1900;
    m.x0 = 16'(cx - ux); m.y0 = 16'(cy - uy);
    m.x1 = 16'(cx + uy); m.y1 = 16'(cy - ux);
    m.x2 = 16'(cx + ux); m.y2 = 16'(cy + uy);
    m.x3 = 16'(cx - uy); m.y3 = 16'(cy + ux);
    return m;
  endfunction

  function automatic marker_t mk(input int x0, y0, x1, y1, x2, y2, x3, y3);
    marker_t m;
    m = '{16'(x0), 16'(y0), 16'(x1), 16'(y1), 16'(x2), 16'(y2), 16'(x3), 16'(y3)};
    return m;
  endfunction

  // driver: present the next pending transaction, holding start while more follow
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_markers.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        marker_t m;
        m = pending_markers.pop_front();
        expected_geometry.insert(expected_geometry.size(), marker_geometry(m));
        markers_sent++;
        start     <= 1'b1;
        corner0_x <= m.x0; corner0_y <= m.y0;
        corner1_x <= m.x1; corner1_y <= m.y1;
        corner2_x <= m.x2; corner2_y <= m.y2;
        corner3_x <= m.x3; corner3_y <= m.y3;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done strobe must match the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_geometry.size() == 0) begin
        $display("unexpected result %0d with nothing outstanding", results_seen);
        error_count++;
      end else begin
        geom_t w;
        w = expected_geometry.pop_front();
        if (centre_x !== w.cx) report_mismatch("centre_x", centre_x, w.cx);
        if (centre_y !== w.cy) report_mismatch("centre_y", centre_y, w.cy);
        if (side_mean !== w.side) report_mismatch("side_mean", side_mean, w.side);
        if (yaw_angle !== w.yaw) report_mismatch("yaw_angle", yaw_angle, w.yaw);
      end
      results_seen++;
    end
  end

  // watchdog: cycles with no transaction accepted on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !stimulus_done) begin
        $display("watchdog expired with %0d results outstanding", expected_geometry.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    corner0_x = '0; corner0_y = '0; corner1_x = '0; corner1_y = '0;
    corner2_x = '0; corner2_y = '0; corner3_x = '0; corner3_y = '0;
    error_count = 0;
    markers_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    stimulus_done = 0;
    send_idle_pct = 6;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and each yaw special case
    queue_marker(mk(0, 0, 0, 0, 0, 0, 0, 0));                      // all zero
    queue_marker(mk(65535, 65535, 65535, 65535,
                    65535, 65535, 65535, 65535));                  // all ones
    queue_marker(mk(0, 0, 65535, 65535, 0, 0, 65535, 65535));      // longest sides
    queue_marker(mk(0, 65535, 65535, 0, 0, 65535, 65535, 0));
    queue_marker(mk(100, 100, 200, 100, 200, 200, 100, 200));      // dy zero, dx > 0
    queue_marker(mk(200, 100, 100, 100, 100, 200, 200, 200));      // dy zero, dx < 0
    queue_marker(mk(100, 100, 100, 200, 0, 200, 0, 100));          // dx zero, dy > 0
    queue_marker(mk(100, 200, 100, 100, 200, 100, 200, 200));      // dx zero, dy < 0
    queue_marker(mk(100, 100, 200, 200, 100, 300, 0, 200));        // 45 degrees
    queue_marker(mk(200, 200, 100, 300, 0, 200, 100, 100));        // 135 degrees
    queue_marker(mk(200, 200, 100, 100, 200, 0, 300, 100));        // -135 degrees
    queue_marker(mk(100, 200, 200, 100, 300, 200, 200, 300));      // -45 degrees
    queue_marker(mk(1000, 500, 0, 499, 0, 0, 1000, 0));            // near -180
    queue_marker(mk(1000, 500, 0, 501, 0, 0, 1000, 0));            // near +180
    queue_marker(mk(0, 0, 65535, 1, 3, 5, 7, 9));
    queue_marker(mk(65535, 0, 0, 65535, 1, 1, 2, 2));
    queue_marker(mk(3, 3, 3, 3, 5, 5, 5, 5));                      // coincident corners

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 66 : 0;
      for (int n = 0; n < 250; n++)
        queue_marker(($urandom_range(0, 99) < 70) ? rand_square()
                     : mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord()));
      wait (pending_markers.size() == 0);
    end

    // drain the pipeline, then keep watching for stray strobes
    wait (expected_geometry.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    stimulus_done = 1;

    $display("sent %0d markers and checked %0d results across three idling phases",
             markers_sent, results_seen);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### filelist.f
sv/smg_pkg.sv
sv/smg_root_cell.sv
sv/smg_cordic_cell.sv
sv/square_marker_geometry.sv
tb/sv/square_marker_geometry_tb.sv
